// ===== src/tct_pkg.sv =====
// Shared types and constants for the tag count table.
// Holds request and result codes, field widths, and the controller/datapath link structs.
// No dependencies.
package tct_pkg;

	// Fixed field widths of the stream payload
	localparam int KEY_W     = 32;
	localparam int AMT_W     = 31;
	localparam int CNT_OUT_W = 31;

	// Parameter defaults
	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int COUNT_BITS_DEF = 31;

	// Request operations
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_SUB    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_QUERY  = 2'd3
	} opcode_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_REJECT  = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic start;   // latch request, rewind scan
		logic issue;   // read next table entry
		logic finish;  // apply update, load result
	} tct_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last_issue; // current read is the final entry
		logic out_free;   // result register can take a new result
	} tct_stat_t;

endpackage

// ===== src/tct_ctrl.sv =====
// Sequencer of the tag count table: accept, scan, drain, update.
// Depends on tct_pkg for the command and status structs.
module tct_ctrl import tct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  tct_stat_t stat,
	output tct_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_UPDATE
	} state_t;

	state_t state_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (stat.last_issue) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Commands decoded from state
	assign s_tready   = (state_q == S_IDLE);
	assign cmd.start  = (state_q == S_IDLE) && s_tvalid;
	assign cmd.issue  = (state_q == S_SCAN);
	assign cmd.finish = (state_q == S_UPDATE) && stat.out_free;

endmodule

// ===== src/tct_datapath.sv =====
// Datapath of the tag count table: key/count store, valid bits, scan compare,
// update arithmetic and the result register. Depends on tct_pkg.
module tct_datapath import tct_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tct_cmd_t             cmd,
	output tct_stat_t            stat,
	input  logic [1:0]           req_op,
	input  logic [KEY_W-1:0]     req_key,
	input  logic [AMT_W-1:0]     req_amount,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [1:0]           res_status,
	output logic [CNT_OUT_W-1:0] res_count,
	output logic                 res_present
);

	localparam int IW    = $clog2(ENTRIES);
	localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int CW    = COUNT_BITS;
	localparam int CWX   = (CW > AMT_W) ? CW : AMT_W;
	localparam int SW    = CWX + 1;
	localparam int CWO   = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

	// Store: keys and counts in memory, valid bits in flops
	logic [KW-1:0] key_mem [ENTRIES];
	logic [CW-1:0] cnt_mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	// Request registers
	opcode_t        op_q;
	logic [KW-1:0]  key_q;
	logic [AMT_W-1:0] amt_q;

	// Scan state
	logic [IW-1:0] idx_q;
	logic          cmp_vld_s1;
	logic [IW-1:0] cmp_idx_s1;
	logic [KW-1:0] rd_key_s1;
	logic [CW-1:0] rd_cnt_s1;
	logic          rd_vld_s1;
	logic          found_q;
	logic [IW-1:0] match_idx_q;
	logic [CW-1:0] match_cnt_q;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;

	// Result register
	logic          res_valid_q;
	logic [1:0]    res_status_q;
	logic [CNT_OUT_W-1:0] res_count_q;
	logic          res_present_q;

	// Update decode
	logic [CW-1:0] cmax;
	logic [SW-1:0] sum_w;
	logic [SW-1:0] diff_w;
	logic [CW-1:0] sum_sat;
	logic [CW-1:0] ins_sat;
	logic          sub_frees;
	logic          key_zero;
	logic          amt_zero;
	status_t       st_c;
	logic [CW-1:0] cnt_c;
	logic          pres_c;
	logic          wr_c;
	logic [IW-1:0] wr_slot_c;
	logic [CW-1:0] wr_cnt_c;
	logic          set_v_c;
	logic          clr_v_c;
	logic [CWO-1:0] cnt_ext;

	assign stat.last_issue = (idx_q == IW'(ENTRIES - 1));
	assign stat.out_free   = !res_valid_q || res_ready;

	// Request latch
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= opcode_t'(req_op);
			key_q <= req_key[KW-1:0];
			amt_q <= req_amount;
		end
	end

	// Scan index and compare stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			cmp_vld_s1   <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.issue;
			if (cmd.start) begin
				idx_q        <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (cmd.issue) idx_q <= idx_q + IW'(1);
				if (cmp_vld_s1) begin
					if (rd_vld_s1 && (rd_key_s1 == key_q) && !found_q) found_q <= 1'b1;
					if (!rd_vld_s1 && !free_found_q) free_found_q <= 1'b1;
				end
			end
		end
	end

	// Match and free slot capture
	always_ff @(posedge clk) begin
		if (cmp_vld_s1) begin
			if (rd_vld_s1 && (rd_key_s1 == key_q) && !found_q) begin
				match_idx_q <= cmp_idx_s1;
				match_cnt_q <= rd_cnt_s1;
			end
			if (!rd_vld_s1 && !free_found_q) free_idx_q <= cmp_idx_s1;
		end
	end

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.finish && wr_c) begin
			key_mem[wr_slot_c] <= key_q;
			cnt_mem[wr_slot_c] <= wr_cnt_c;
		end
		if (cmd.issue) begin
			rd_key_s1  <= key_mem[idx_q];
			rd_cnt_s1  <= cnt_mem[idx_q];
			cmp_idx_s1 <= idx_q;
		end
	end

	// Valid bits and their read copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.issue) rd_vld_s1 <= valid_q[idx_q];
			if (cmd.finish && set_v_c) valid_q[wr_slot_c] <= 1'b1;
			if (cmd.finish && clr_v_c) valid_q[match_idx_q] <= 1'b0;
		end
	end

	// Count arithmetic
	assign cmax      = '1;
	assign sum_w     = SW'(match_cnt_q) + SW'(amt_q);
	assign diff_w    = SW'(match_cnt_q) - SW'(amt_q);
	assign sum_sat   = (sum_w > SW'(cmax)) ? cmax : sum_w[CW-1:0];
	assign ins_sat   = (SW'(amt_q) > SW'(cmax)) ? cmax : CW'(amt_q);
	assign sub_frees = (SW'(match_cnt_q) <= SW'(amt_q));
	assign key_zero  = (key_q == '0);
	assign amt_zero  = (amt_q == '0);

	// Outcome of the request
	always_comb begin
		st_c      = ST_DONE;
		cnt_c     = '0;
		pres_c    = 1'b0;
		wr_c      = 1'b0;
		wr_slot_c = match_idx_q;
		wr_cnt_c  = sum_sat;
		set_v_c   = 1'b0;
		clr_v_c   = 1'b0;
		if (key_zero) begin
			st_c = ST_REJECT;
		end else if (((op_q == OP_ADD) || (op_q == OP_SUB)) && amt_zero) begin
			st_c = ST_REJECT;
			if (found_q) begin
				cnt_c  = match_cnt_q;
				pres_c = 1'b1;
			end
		end else begin
			case (op_q)
				OP_ADD: begin
					if (found_q) begin
						wr_c   = 1'b1;
						cnt_c  = sum_sat;
						pres_c = 1'b1;
					end else if (free_found_q) begin
						wr_c      = 1'b1;
						wr_slot_c = free_idx_q;
						wr_cnt_c  = ins_sat;
						set_v_c   = 1'b1;
						cnt_c     = ins_sat;
						pres_c    = 1'b1;
					end else begin
						st_c = ST_FULL;
					end
				end
				OP_SUB: begin
					if (!found_q) begin
						st_c = ST_MISSING;
					end else if (sub_frees) begin
						clr_v_c = 1'b1;
					end else begin
						wr_c     = 1'b1;
						wr_cnt_c = diff_w[CW-1:0];
						cnt_c    = diff_w[CW-1:0];
						pres_c   = 1'b1;
					end
				end
				OP_REMOVE: begin
					if (!found_q) st_c = ST_MISSING;
					else clr_v_c = 1'b1;
				end
				default: begin
					if (!found_q) begin
						st_c = ST_MISSING;
					end else begin
						cnt_c  = match_cnt_q;
						pres_c = 1'b1;
					end
				end
			endcase
		end
	end

	assign cnt_ext = CWO'(cnt_c);

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_status_q  <= st_c;
			res_count_q   <= cnt_ext[CNT_OUT_W-1:0];
			res_present_q <= pres_c;
		end
	end

	assign res_valid   = res_valid_q;
	assign res_status  = res_status_q;
	assign res_count   = res_count_q;
	assign res_present = res_present_q;

endmodule

// ===== src/tag_count_table_top.sv =====
// Top level of the tag count table: stream ports, controller and datapath.
// Depends on tct_pkg, tct_ctrl and tct_datapath.
//
// A fixed table of ENTRIES key/count pairs. Each request beat (opcode in s_tuser,
// key and amount in s_tdata) yields exactly one result beat (status in m_tuser,
// count and present flag in m_tdata). Add raises a key's count with saturation
// at 2^COUNT_BITS-1 or inserts it into the lowest free entry; subtract lowers it
// and frees the entry at zero or below; remove frees it; query reports it. Key 0,
// and amount 0 on add or subtract, are rejected. A request passes through an accept
// state, a scan state that reads each table entry in turn through the single memory
// read port, a drain state for the last compare and an update state. The next request
// is taken once the update is done; the update waits only while the previous result
// is still held in the output register. No clearing pass is needed after reset.
module tag_count_table_top import tct_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] key, [62:32] amount, [63] zero
	input  logic [1:0]  s_tuser,  // [1:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [30:0] count_now, [31] present
	output logic [1:0]  m_tuser   // [1:0] status
);

	tct_cmd_t  cmd;
	tct_stat_t stat;
	logic [CNT_OUT_W-1:0] res_count;
	logic res_present;

	tct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tct_datapath #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_op      (s_tuser),
		.req_key     (s_tdata[KEY_W-1:0]),
		.req_amount  (s_tdata[KEY_W+AMT_W-1:KEY_W]),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res_status  (m_tuser),
		.res_count   (res_count),
		.res_present (res_present)
	);

	// Result beat packing
	assign m_tdata = {res_present, res_count};

endmodule
